/* hw/rtl/fsq_pkg.sv */
// Shared types and constants for the Q16.16 square root pipeline.
package fsq_pkg;

   // Field widths
   localparam int unsigned OPERAND_W = 32;
   localparam int unsigned ROOT_W    = 25;
   localparam int unsigned WORK_W    = 32;

   // Restoring passes: the first yields the integer root, the second the low 8 bits
   localparam int unsigned PASS1_STEPS   = 16;
   localparam int unsigned PASS1_TOP_BIT = 30;
   localparam int unsigned PASS2_STEPS   = 8;
   localparam int unsigned PASS2_TOP_BIT = 14;

   // Rescale between passes
   localparam logic [WORK_W-1:0] REM_LIMIT = 32'd65535;
   localparam logic [WORK_W-1:0] HALF_LSB  = 32'h0000_8000;

   // Largest root magnitude (root of 2^31 in Q16.16, rounded)
   localparam logic [ROOT_W-1:0] ROOT_MAX = 25'd11863283;

   // Word carried between stages
   typedef struct packed {
      logic              neg;
      logic [WORK_W-1:0] rem;
      logic [WORK_W-1:0] acc;
   } fsq_data_type;

endpackage

/* hw/rtl/fsq_front.sv */
// Entry stage: takes the operand magnitude and starts the remainder.
module fsq_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic                                in_valid,
   input  logic signed [fsq_pkg::OPERAND_W-1:0] in_operand,
   output logic                                out_valid,
   output fsq_pkg::fsq_data_type               out_data
);
   import fsq_pkg::*;

   logic         valid_ff;
   fsq_data_type data_ff;
   fsq_data_type data_in;

   // Magnitude: the most negative value maps to unsigned 2^31
   always_comb begin
      data_in.neg = in_operand[OPERAND_W-1];
      data_in.rem = in_operand[OPERAND_W-1] ? (WORK_W'(0) - WORK_W'(in_operand))
                                            : WORK_W'(in_operand);
      data_in.acc = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hw/rtl/fsq_step.sv */
// One restoring square-root step followed by its stage register.
module fsq_step (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic [fsq_pkg::WORK_W-1:0]       step_bit,
   input  logic                             in_valid,
   input  fsq_pkg::fsq_data_type            in_data,
   output logic                             out_valid,
   output fsq_pkg::fsq_data_type            out_data
);
   import fsq_pkg::*;

   logic              valid_ff;
   fsq_data_type      data_ff;
   fsq_data_type      data_in;
   logic [WORK_W-1:0] trial;

   // Subtract the trial square when it fits, shift the partial root
   always_comb begin
      trial       = in_data.acc + step_bit;
      data_in.neg = in_data.neg;
      if (in_data.rem >= trial) begin
         data_in.rem = in_data.rem - trial;
         data_in.acc = (in_data.acc >> 1) + step_bit;
      end else begin
         data_in.rem = in_data.rem;
         data_in.acc = in_data.acc >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hw/rtl/fsq_rescale.sv */
// Between passes: scales remainder and root up by 16 bits, adjusting both when the remainder is large.
module fsq_rescale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  fsq_pkg::fsq_data_type in_data,
   output logic                  out_valid,
   output fsq_pkg::fsq_data_type out_data
);
   import fsq_pkg::*;

   logic              valid_ff;
   fsq_data_type      data_ff;
   fsq_data_type      data_in;
   logic [WORK_W-1:0] diff;

   // Large remainder: advance the root by a half after the shift
   always_comb begin
      diff        = in_data.rem - in_data.acc;
      data_in.neg = in_data.neg;
      if (in_data.rem > REM_LIMIT) begin
         data_in.rem = {diff[15:0], 16'h0000} - HALF_LSB;
         data_in.acc = {in_data.acc[15:0], 16'h0000} + HALF_LSB;
      end else begin
         data_in.rem = {in_data.rem[15:0], 16'h0000};
         data_in.acc = {in_data.acc[15:0], 16'h0000};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hw/rtl/fsq_finish.sv */
// Exit stage: rounds, restores the sign and holds the result word.
module fsq_finish (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic                              in_valid,
   input  fsq_pkg::fsq_data_type             in_data,
   output logic                              out_valid,
   output logic signed [fsq_pkg::ROOT_W-1:0] out_root
);
   import fsq_pkg::*;

   logic              valid_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [ROOT_W-1:0] root_in;
   logic [WORK_W-1:0] rounded;
   logic [WORK_W-1:0] signed_root;

   // Round up when the remainder exceeds the root, then apply the sign
   always_comb begin
      rounded     = (in_data.rem > in_data.acc) ? (in_data.acc + WORK_W'(1)) : in_data.acc;
      signed_root = in_data.neg ? (WORK_W'(0) - rounded) : rounded;
      root_in     = signed_root[ROOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_root  = $signed(root_ff);

endmodule

/* hw/rtl/q16_16_fixed_sqrt_unit.sv */
// Top level of the pipelined Q16.16 square root unit.
//
//   channel   direction   ports                         word
//   req       in          req_valid req_stall           req_operand  (s32, Q16.16)
//   rsp       out         rsp_valid rsp_stall           rsp_root     (s25, Q9.16)
//
// Throughput one word per cycle while no result waits under rsp_stall; stages: entry stage, 16 restoring
// steps for the integer root, rescale stage, 8 steps for the fraction, exit stage.
// Each restoring step (one 32-bit add, compare, subtract) owns one stage.
// Reset clears every stage valid bit; the data registers are not reset.
// A result held with rsp_stall high freezes the whole pipeline and raises
// req_stall in the same cycle; nothing is dropped or repeated.
module q16_16_fixed_sqrt_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [fsq_pkg::OPERAND_W-1:0] req_operand,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fsq_pkg::ROOT_W-1:0]    rsp_root
);
   import fsq_pkg::*;

   logic         enable;
   logic         p1_valid [0:PASS1_STEPS];
   fsq_data_type p1_data  [0:PASS1_STEPS];
   logic         p2_valid [0:PASS2_STEPS];
   fsq_data_type p2_data  [0:PASS2_STEPS];

   // Global advance: hold everything while the output word waits
   assign enable    = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;

   fsq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_valid   (req_valid),
      .in_operand (req_operand),
      .out_valid  (p1_valid[0]),
      .out_data   (p1_data[0])
   );

   // First pass: trial bits 2^30 down to 2^0
   for (genvar i = 0; i < PASS1_STEPS; i++) begin : g_pass1
      localparam logic [WORK_W-1:0] StepBit = WORK_W'(1) << (PASS1_TOP_BIT - 2 * i);
      fsq_step u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .step_bit  (StepBit),
         .in_valid  (p1_valid[i]),
         .in_data   (p1_data[i]),
         .out_valid (p1_valid[i+1]),
         .out_data  (p1_data[i+1])
      );
   end

   fsq_rescale u_rescale (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (p1_valid[PASS1_STEPS]),
      .in_data   (p1_data[PASS1_STEPS]),
      .out_valid (p2_valid[0]),
      .out_data  (p2_data[0])
   );

   // Second pass: trial bits 2^14 down to 2^0
   for (genvar j = 0; j < PASS2_STEPS; j++) begin : g_pass2
      localparam logic [WORK_W-1:0] StepBit = WORK_W'(1) << (PASS2_TOP_BIT - 2 * j);
      fsq_step u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .step_bit  (StepBit),
         .in_valid  (p2_valid[j]),
         .in_data   (p2_data[j]),
         .out_valid (p2_valid[j+1]),
         .out_data  (p2_data[j+1])
      );
   end

   fsq_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (p2_valid[PASS2_STEPS]),
      .in_data   (p2_data[PASS2_STEPS]),
      .out_valid (rsp_valid),
      .out_root  (rsp_root)
   );

   // After the integer pass the remainder never exceeds twice the root
   a_pass1_rem_bound: assert property (@(posedge clock) disable iff (reset)
      p1_valid[PASS1_STEPS] |->
         (p1_data[PASS1_STEPS].rem <= {p1_data[PASS1_STEPS].acc[WORK_W-2:0], 1'b0}))
      else $error("remainder out of bound after first pass");

   // Result magnitude stays within the root of the largest operand
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_root <= $signed(ROOT_MAX) && rsp_root >= -$signed(ROOT_MAX)))
      else $error("root outside its range");

   // A frozen pipeline keeps the pending result word unchanged
   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_root)))
      else $error("pending result changed while stalled");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !p1_valid[0] && !p2_valid[0]))
      else $error("pipeline not empty after reset");

endmodule
